>>> design/sddc_pkg.sv
// shared types, constants and codes for the skid-drive dc motor torque unit
// no dependencies; used by every other file of the block
package sddc_pkg;

   localparam int WHEEL_COUNT = 4;
   localparam int WHEEL_IDX_W = $clog2(WHEEL_COUNT);
   localparam int DUTY_W      = 16;
   localparam int SPEED_W     = 24;
   localparam int TORQUE_W    = 32;
   localparam int OPND_W      = 48;
   localparam int SAT_W       = OPND_W - 1;
   localparam int COEF_W      = 24;
   localparam int HALF_W      = OPND_W / 2;
   localparam int ACC_W       = OPND_W + COEF_W;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic signed [DUTY_W-1:0] DUTY_ONE       = 16'sd16384;
   localparam logic [COEF_W-1:0]        PI_OVER_30_Q24 = 24'd1756906;
   localparam logic [SAT_W-1:0]         NO_SAT         = 47'h3FFF_FFFF_FFFF;
   localparam logic [SAT_W-1:0]         DIFF_SAT       = 47'h007F_FFFF_FFFF;
   localparam logic [SAT_W-1:0]         CURR_SAT       = 47'h03FF_FFFF_FFFF;
   localparam logic [SAT_W-1:0]         INT32_SAT      = 47'h0000_7FFF_FFFF;

   localparam logic [CSR_INDEX_W-1:0] CSR_SUPPLY_VOLTAGE      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TORQUE_GAIN         = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GEAR_RATIO          = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDING_CONDUCTANCE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TORQUE_LIMIT        = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEAD_ZONE_DUTY      = 3'd5;

   typedef enum logic [1:0] {
      ACT_FORWARD = 2'd0,
      ACT_RIGHT   = 2'd1,
      ACT_SET     = 2'd2,
      ACT_TICK    = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_ROUND,
      ST_DIFF,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      OP_MOTOR_RPM,
      OP_OMEGA,
      OP_EMF,
      OP_DRIVE,
      OP_CURRENT,
      OP_TORQUE,
      OP_WHEEL
   } op_type;

   typedef enum logic [1:0] {
      MUL_HOLD,
      MUL_LOAD,
      MUL_ACC
   } mul_phase_type;

   typedef enum logic [2:0] {
      SH_0,
      SH_6,
      SH_8,
      SH_16,
      SH_24
   } shift_type;

   typedef struct packed {
      mul_phase_type    phase;
      shift_type        shift;
      logic [SAT_W-1:0] sat_lim;
      logic             neg_extra;
   } mul_ctrl_type;

   typedef struct packed {
      logic [1:0]                 action;
      logic signed [DUTY_W-1:0]   amount;
      logic signed [DUTY_W-1:0]   duty_front_left;
      logic signed [DUTY_W-1:0]   duty_front_right;
      logic signed [DUTY_W-1:0]   duty_rear_left;
      logic signed [DUTY_W-1:0]   duty_rear_right;
      logic signed [SPEED_W-1:0]  speed_front_left;
      logic signed [SPEED_W-1:0]  speed_front_right;
      logic signed [SPEED_W-1:0]  speed_rear_left;
      logic signed [SPEED_W-1:0]  speed_rear_right;
   } req_payload_type;

   typedef struct packed {
      logic                       torque_valid;
      logic signed [TORQUE_W-1:0] torque_front_left;
      logic signed [TORQUE_W-1:0] torque_front_right;
      logic signed [TORQUE_W-1:0] torque_rear_left;
      logic signed [TORQUE_W-1:0] torque_rear_right;
      logic signed [DUTY_W-1:0]   now_duty_front_left;
      logic signed [DUTY_W-1:0]   now_duty_front_right;
      logic signed [DUTY_W-1:0]   now_duty_rear_left;
      logic signed [DUTY_W-1:0]   now_duty_rear_right;
   } rsp_payload_type;

   function automatic logic signed [DUTY_W-1:0] clamp_duty(
      input logic signed [DUTY_W+1:0] x
   );
      logic signed [DUTY_W+1:0] one;
      one = (DUTY_W+2)'(DUTY_ONE);
      if (x > one) begin
         return DUTY_ONE;
      end else if (x < -one) begin
         return -DUTY_ONE;
      end
      return x[DUTY_W-1:0];
   endfunction

endpackage

>>> design/sddc_if.sv
// valid/ready channel interfaces for request and response beats
// depends on sddc_pkg for the payload types
interface sddc_req_if;
   logic                      valid;
   logic                      ready;
   sddc_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface sddc_rsp_if;
   logic                      valid;
   logic                      ready;
   sddc_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> design/sddc_mul_unit.sv
// shared signed-by-unsigned multiply unit: two partial products, then round and saturate
// depends on sddc_pkg for widths and control struct
module sddc_mul_unit (
   input  logic                                  clock,
   input  sddc_pkg::mul_ctrl_type                ctrl,
   input  logic signed [sddc_pkg::OPND_W-1:0]    a,
   input  logic [sddc_pkg::COEF_W-1:0]           b,
   output logic signed [sddc_pkg::OPND_W-1:0]    result
);

   logic signed [sddc_pkg::HALF_W:0]           mul_x;
   logic signed [sddc_pkg::COEF_W:0]           mul_y;
   logic signed [sddc_pkg::HALF_W+sddc_pkg::COEF_W+1:0] prod;
   logic signed [sddc_pkg::ACC_W-1:0]          prod_lo;
   logic signed [sddc_pkg::ACC_W-1:0]          prod_hi;
   logic signed [sddc_pkg::ACC_W-1:0]          acc_ff;
   logic signed [sddc_pkg::ACC_W-1:0]          acc_in;
   logic signed [sddc_pkg::ACC_W-1:0]          half;
   logic signed [sddc_pkg::ACC_W-1:0]          rnd;
   logic signed [sddc_pkg::ACC_W-1:0]          shifted;
   logic signed [sddc_pkg::ACC_W-1:0]          upper;
   logic signed [sddc_pkg::ACC_W-1:0]          lower;
   logic signed [sddc_pkg::ACC_W-1:0]          extra;

   // low half unsigned, high half signed
   assign mul_x = (ctrl.phase == sddc_pkg::MUL_LOAD)
                ? $signed({1'b0, a[sddc_pkg::HALF_W-1:0]})
                : $signed({a[sddc_pkg::OPND_W-1], a[sddc_pkg::OPND_W-1:sddc_pkg::HALF_W]});
   assign mul_y = $signed({1'b0, b});
   assign prod  = mul_x * mul_y;

   assign prod_lo = sddc_pkg::ACC_W'(prod);
   assign prod_hi = $signed({prod[sddc_pkg::OPND_W-1:0], {sddc_pkg::HALF_W{1'b0}}});

   always_comb begin
      case (ctrl.phase)
         sddc_pkg::MUL_LOAD: begin
            acc_in = prod_lo;
         end
         sddc_pkg::MUL_ACC: begin
            acc_in = acc_ff + prod_hi;
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // round half up, then floor shift
   always_comb begin
      half = '0;
      case (ctrl.shift)
         sddc_pkg::SH_6:  half[5]  = 1'b1;
         sddc_pkg::SH_8:  half[7]  = 1'b1;
         sddc_pkg::SH_16: half[15] = 1'b1;
         sddc_pkg::SH_24: half[23] = 1'b1;
         default:         half     = '0;
      endcase
      rnd = acc_ff + half;
      case (ctrl.shift)
         sddc_pkg::SH_6:  shifted = rnd >>> 6;
         sddc_pkg::SH_8:  shifted = rnd >>> 8;
         sddc_pkg::SH_16: shifted = rnd >>> 16;
         sddc_pkg::SH_24: shifted = rnd >>> 24;
         default:         shifted = rnd;
      endcase
   end

   assign upper = sddc_pkg::ACC_W'($signed({1'b0, ctrl.sat_lim}));
   assign extra = $signed({{(sddc_pkg::ACC_W-1){1'b0}}, ctrl.neg_extra});
   assign lower = -upper - extra;

   always_comb begin
      if (shifted > upper) begin
         result = upper[sddc_pkg::OPND_W-1:0];
      end else if (shifted < lower) begin
         result = lower[sddc_pkg::OPND_W-1:0];
      end else begin
         result = shifted[sddc_pkg::OPND_W-1:0];
      end
   end

endmodule

>>> design/skid_drive_dc_motor_torque_unit.sv
// top level of the skid-drive dc motor torque unit: csr bank, duty state and sequencer
// depends on sddc_pkg, sddc_if and sddc_mul_unit
// move/set beats: the accept moves to the done state, which loads the rsp register once it is free
// tick: per wheel one check, seven multiplier passes (each mul_lo, mul_hi, round)
//   and one subtract; a stopped wheel inside the dead zone is finished at its check
// throughput: one beat in flight; the next req is taken once the result is in the rsp register
// reset: synchronous, clears duties, csr values to defaults, sequencer and rsp valid
module skid_drive_dc_motor_torque_unit (
   input  logic                               clock,
   input  logic                               reset,
   sddc_req_if.sink                           req_chan,
   sddc_rsp_if.source                         rsp_chan,
   input  logic                               csr_write_en,
   input  logic [sddc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [sddc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic [15:0] supply_voltage_ff, supply_voltage_in;
   logic [19:0] torque_gain_ff, torque_gain_in;
   logic [15:0] gear_ratio_ff, gear_ratio_in;
   logic [23:0] winding_conductance_ff, winding_conductance_in;
   logic [23:0] torque_limit_ff, torque_limit_in;
   logic [14:0] dead_zone_duty_ff, dead_zone_duty_in;

   sddc_pkg::state_type state_ff, state_in;
   sddc_pkg::op_type    op_ff, op_in;
   logic [sddc_pkg::WHEEL_IDX_W-1:0] wheel_ff, wheel_in;
   logic tick_ff, tick_in;
   logic rsp_valid_ff, rsp_valid_in;
   sddc_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic signed [sddc_pkg::DUTY_W-1:0]   duty_ff   [sddc_pkg::WHEEL_COUNT];
   logic signed [sddc_pkg::DUTY_W-1:0]   duty_in   [sddc_pkg::WHEEL_COUNT];
   logic signed [sddc_pkg::SPEED_W-1:0]  speed_ff  [sddc_pkg::WHEEL_COUNT];
   logic signed [sddc_pkg::SPEED_W-1:0]  speed_in  [sddc_pkg::WHEEL_COUNT];
   logic signed [sddc_pkg::TORQUE_W-1:0] torque_ff [sddc_pkg::WHEEL_COUNT];
   logic signed [sddc_pkg::TORQUE_W-1:0] torque_in [sddc_pkg::WHEEL_COUNT];

   logic signed [sddc_pkg::OPND_W-1:0] x_ff, x_in;
   logic signed [sddc_pkg::OPND_W-1:0] y_ff, y_in;
   logic signed [sddc_pkg::OPND_W-1:0] diff;
   logic signed [sddc_pkg::OPND_W-1:0] diff_lim;

   sddc_pkg::mul_ctrl_type             mul_ctrl;
   logic signed [sddc_pkg::OPND_W-1:0] mul_a;
   logic [sddc_pkg::COEF_W-1:0]        mul_b;
   logic signed [sddc_pkg::OPND_W-1:0] mul_result;

   sddc_pkg::req_payload_type          req;
   logic signed [sddc_pkg::DUTY_W+1:0] amount_ext;
   logic signed [sddc_pkg::DUTY_W+1:0] step_ext;
   logic signed [sddc_pkg::DUTY_W:0]   duty_mag;
   logic signed [sddc_pkg::DUTY_W-1:0] cur_duty;
   logic                               req_ready;
   logic                               rsp_free;

   assign req       = req_chan.payload;
   assign req_chan.ready = req_ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_chan.ready;

   // csr bank
   always_comb begin
      supply_voltage_in      = supply_voltage_ff;
      torque_gain_in         = torque_gain_ff;
      gear_ratio_in          = gear_ratio_ff;
      winding_conductance_in = winding_conductance_ff;
      torque_limit_in        = torque_limit_ff;
      dead_zone_duty_in      = dead_zone_duty_ff;
      if (csr_write_en) begin
         case (csr_index)
            sddc_pkg::CSR_SUPPLY_VOLTAGE:      supply_voltage_in      = csr_wdata[15:0];
            sddc_pkg::CSR_TORQUE_GAIN:         torque_gain_in         = csr_wdata[19:0];
            sddc_pkg::CSR_GEAR_RATIO:          gear_ratio_in          = csr_wdata[15:0];
            sddc_pkg::CSR_WINDING_CONDUCTANCE: winding_conductance_in = csr_wdata[23:0];
            sddc_pkg::CSR_TORQUE_LIMIT:        torque_limit_in        = csr_wdata[23:0];
            sddc_pkg::CSR_DEAD_ZONE_DUTY:      dead_zone_duty_in      = csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         supply_voltage_ff      <= 16'd3072;
         torque_gain_ff         <= 20'd6554;
         gear_ratio_ff          <= 16'd12800;
         winding_conductance_ff <= 24'd65536;
         torque_limit_ff        <= 24'd7714;
         dead_zone_duty_ff      <= 15'd0;
      end else begin
         supply_voltage_ff      <= supply_voltage_in;
         torque_gain_ff         <= torque_gain_in;
         gear_ratio_ff          <= gear_ratio_in;
         winding_conductance_ff <= winding_conductance_in;
         torque_limit_ff        <= torque_limit_in;
         dead_zone_duty_ff      <= dead_zone_duty_in;
      end
   end

   // operand select and round/saturate mode per step
   always_comb begin
      mul_ctrl.phase     = sddc_pkg::MUL_HOLD;
      mul_ctrl.shift     = sddc_pkg::SH_0;
      mul_ctrl.sat_lim   = sddc_pkg::NO_SAT;
      mul_ctrl.neg_extra = 1'b0;
      case (op_ff)
         sddc_pkg::OP_MOTOR_RPM: begin
            mul_a = sddc_pkg::OPND_W'(speed_ff[wheel_ff]);
            mul_b = sddc_pkg::COEF_W'(gear_ratio_ff);
         end
         sddc_pkg::OP_OMEGA: begin
            mul_a = x_ff;
            mul_b = sddc_pkg::PI_OVER_30_Q24;
            mul_ctrl.shift = sddc_pkg::SH_24;
         end
         sddc_pkg::OP_EMF: begin
            mul_a = x_ff;
            mul_b = sddc_pkg::COEF_W'(torque_gain_ff);
            mul_ctrl.shift = sddc_pkg::SH_16;
         end
         sddc_pkg::OP_DRIVE: begin
            mul_a = sddc_pkg::OPND_W'(duty_ff[wheel_ff]);
            mul_b = sddc_pkg::COEF_W'(supply_voltage_ff);
            mul_ctrl.shift = sddc_pkg::SH_6;
         end
         sddc_pkg::OP_CURRENT: begin
            mul_a = x_ff;
            mul_b = winding_conductance_ff;
            mul_ctrl.shift   = sddc_pkg::SH_16;
            mul_ctrl.sat_lim = sddc_pkg::CURR_SAT;
         end
         sddc_pkg::OP_TORQUE: begin
            mul_a = x_ff;
            mul_b = sddc_pkg::COEF_W'(torque_gain_ff);
            mul_ctrl.shift   = sddc_pkg::SH_16;
            mul_ctrl.sat_lim = sddc_pkg::SAT_W'(torque_limit_ff);
         end
         default: begin
            mul_a = x_ff;
            mul_b = sddc_pkg::COEF_W'(gear_ratio_ff);
            mul_ctrl.shift     = sddc_pkg::SH_8;
            mul_ctrl.sat_lim   = sddc_pkg::INT32_SAT;
            mul_ctrl.neg_extra = 1'b1;
         end
      endcase
      case (state_ff)
         sddc_pkg::ST_MUL_LO: mul_ctrl.phase = sddc_pkg::MUL_LOAD;
         sddc_pkg::ST_MUL_HI: mul_ctrl.phase = sddc_pkg::MUL_ACC;
         default:             mul_ctrl.phase = sddc_pkg::MUL_HOLD;
      endcase
   end

   sddc_mul_unit u_mul (
      .clock  (clock),
      .ctrl   (mul_ctrl),
      .a      (mul_a),
      .b      (mul_b),
      .result (mul_result)
   );

   assign diff     = y_ff - x_ff;
   assign diff_lim = $signed({1'b0, sddc_pkg::DIFF_SAT});
   assign cur_duty = duty_ff[wheel_ff];
   assign duty_mag = (cur_duty < 0) ? -(sddc_pkg::DUTY_W+1)'(cur_duty)
                                    : (sddc_pkg::DUTY_W+1)'(cur_duty);
   assign amount_ext = (sddc_pkg::DUTY_W+2)'(req.amount);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      wheel_in     = wheel_ff;
      tick_in      = tick_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      duty_in      = duty_ff;
      speed_in     = speed_ff;
      torque_in    = torque_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      req_ready    = 1'b0;
      step_ext     = '0;
      case (state_ff)
         sddc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_chan.valid) begin
               tick_in  = (req.action == sddc_pkg::ACT_TICK);
               state_in = sddc_pkg::ST_DONE;
               case (req.action)
                  sddc_pkg::ACT_FORWARD: begin
                     for (int i = 0; i < sddc_pkg::WHEEL_COUNT; i++) begin
                        duty_in[i] = sddc_pkg::clamp_duty(
                           (sddc_pkg::DUTY_W+2)'(duty_ff[i]) + amount_ext);
                     end
                  end
                  sddc_pkg::ACT_RIGHT: begin
                     for (int i = 0; i < sddc_pkg::WHEEL_COUNT; i++) begin
                        step_ext   = (i % 2 == 1) ? -amount_ext : amount_ext;
                        duty_in[i] = sddc_pkg::clamp_duty(
                           (sddc_pkg::DUTY_W+2)'(duty_ff[i]) + step_ext);
                     end
                  end
                  sddc_pkg::ACT_SET: begin
                     duty_in[0] = sddc_pkg::clamp_duty((sddc_pkg::DUTY_W+2)'(req.duty_front_left));
                     duty_in[1] = sddc_pkg::clamp_duty((sddc_pkg::DUTY_W+2)'(req.duty_front_right));
                     duty_in[2] = sddc_pkg::clamp_duty((sddc_pkg::DUTY_W+2)'(req.duty_rear_left));
                     duty_in[3] = sddc_pkg::clamp_duty((sddc_pkg::DUTY_W+2)'(req.duty_rear_right));
                  end
                  default: begin
                     speed_in[0] = req.speed_front_left;
                     speed_in[1] = req.speed_front_right;
                     speed_in[2] = req.speed_rear_left;
                     speed_in[3] = req.speed_rear_right;
                     wheel_in    = '0;
                     op_in       = sddc_pkg::OP_MOTOR_RPM;
                     state_in    = sddc_pkg::ST_CHECK;
                  end
               endcase
            end
         end
         sddc_pkg::ST_CHECK: begin
            op_in = sddc_pkg::OP_MOTOR_RPM;
            if (speed_ff[wheel_ff] == '0
                && duty_mag <= (sddc_pkg::DUTY_W+1)'(dead_zone_duty_ff)) begin
               // stopped wheel inside the dead zone
               torque_in[wheel_ff] = '0;
               if (wheel_ff == sddc_pkg::WHEEL_IDX_W'(sddc_pkg::WHEEL_COUNT - 1)) begin
                  state_in = sddc_pkg::ST_DONE;
               end else begin
                  wheel_in = wheel_ff + 1'b1;
               end
            end else begin
               state_in = sddc_pkg::ST_MUL_LO;
            end
         end
         sddc_pkg::ST_MUL_LO: begin
            state_in = sddc_pkg::ST_MUL_HI;
         end
         sddc_pkg::ST_MUL_HI: begin
            state_in = sddc_pkg::ST_ROUND;
         end
         sddc_pkg::ST_ROUND: begin
            state_in = sddc_pkg::ST_MUL_LO;
            case (op_ff)
               sddc_pkg::OP_MOTOR_RPM: begin
                  x_in  = mul_result;
                  op_in = sddc_pkg::OP_OMEGA;
               end
               sddc_pkg::OP_OMEGA: begin
                  x_in  = mul_result;
                  op_in = sddc_pkg::OP_EMF;
               end
               sddc_pkg::OP_EMF: begin
                  x_in  = mul_result;
                  op_in = sddc_pkg::OP_DRIVE;
               end
               sddc_pkg::OP_DRIVE: begin
                  y_in     = mul_result;
                  state_in = sddc_pkg::ST_DIFF;
               end
               sddc_pkg::OP_CURRENT: begin
                  x_in  = mul_result;
                  op_in = sddc_pkg::OP_TORQUE;
               end
               sddc_pkg::OP_TORQUE: begin
                  x_in  = mul_result;
                  op_in = sddc_pkg::OP_WHEEL;
               end
               default: begin
                  torque_in[wheel_ff] = mul_result[sddc_pkg::TORQUE_W-1:0];
                  op_in = sddc_pkg::OP_MOTOR_RPM;
                  if (wheel_ff == sddc_pkg::WHEEL_IDX_W'(sddc_pkg::WHEEL_COUNT - 1)) begin
                     state_in = sddc_pkg::ST_DONE;
                  end else begin
                     wheel_in = wheel_ff + 1'b1;
                     state_in = sddc_pkg::ST_CHECK;
                  end
               end
            endcase
         end
         sddc_pkg::ST_DIFF: begin
            // drive minus back-emf, saturated
            if (diff > diff_lim) begin
               x_in = diff_lim;
            end else if (diff < -diff_lim) begin
               x_in = -diff_lim;
            end else begin
               x_in = diff;
            end
            op_in    = sddc_pkg::OP_CURRENT;
            state_in = sddc_pkg::ST_MUL_LO;
         end
         sddc_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in                     = 1'b1;
               rsp_data_in.torque_valid         = tick_ff;
               rsp_data_in.torque_front_left    = tick_ff ? torque_ff[0] : '0;
               rsp_data_in.torque_front_right   = tick_ff ? torque_ff[1] : '0;
               rsp_data_in.torque_rear_left     = tick_ff ? torque_ff[2] : '0;
               rsp_data_in.torque_rear_right    = tick_ff ? torque_ff[3] : '0;
               rsp_data_in.now_duty_front_left  = duty_ff[0];
               rsp_data_in.now_duty_front_right = duty_ff[1];
               rsp_data_in.now_duty_rear_left   = duty_ff[2];
               rsp_data_in.now_duty_rear_right  = duty_ff[3];
               state_in                         = sddc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sddc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sddc_pkg::ST_IDLE;
         op_ff        <= sddc_pkg::OP_MOTOR_RPM;
         wheel_ff     <= '0;
         tick_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < sddc_pkg::WHEEL_COUNT; i++) begin
            duty_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         wheel_ff     <= wheel_in;
         tick_ff      <= tick_in;
         rsp_valid_ff <= rsp_valid_in;
         duty_ff      <= duty_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      y_ff        <= y_in;
      speed_ff    <= speed_in;
      torque_ff   <= torque_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

>>> design/sddc_checker.sv
// port-level checks for the skid-drive dc motor torque unit, bound to the top level
// depends on sddc_pkg and skid_drive_dc_motor_torque_unit
module sddc_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input sddc_pkg::rsp_payload_type rsp_payload
);

   // a stalled rsp beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp beat changed while stalled");

   // nothing pending right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // one beat in flight: busy right after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req taken while busy");

   // non-tick results carry zero torque
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.torque_valid |->
         rsp_payload.torque_front_left == '0 && rsp_payload.torque_front_right == '0 &&
         rsp_payload.torque_rear_left == '0 && rsp_payload.torque_rear_right == '0)
      else $error("torque on a non-tick beat");

   // duties stay clamped
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_payload.now_duty_front_left <= sddc_pkg::DUTY_ONE &&
         rsp_payload.now_duty_front_left >= -sddc_pkg::DUTY_ONE &&
         rsp_payload.now_duty_front_right <= sddc_pkg::DUTY_ONE &&
         rsp_payload.now_duty_front_right >= -sddc_pkg::DUTY_ONE &&
         rsp_payload.now_duty_rear_left <= sddc_pkg::DUTY_ONE &&
         rsp_payload.now_duty_rear_left >= -sddc_pkg::DUTY_ONE &&
         rsp_payload.now_duty_rear_right <= sddc_pkg::DUTY_ONE &&
         rsp_payload.now_duty_rear_right >= -sddc_pkg::DUTY_ONE)
      else $error("duty out of range");

endmodule

bind skid_drive_dc_motor_torque_unit sddc_checker u_sddc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);

>>> tb/tb_skid_drive_dc_motor_torque_unit.sv
// testbench for the skid-drive dc motor torque unit: directed and random beats
// checked against an in-bench fixed-point motor model under several csr settings
// depends on sddc_pkg, sddc_if and skid_drive_dc_motor_torque_unit
module tb_skid_drive_dc_motor_torque_unit;

   localparam int          QUIET_LIMIT = 10000;
   localparam longint      PI_Q24      = longint'(sddc_pkg::PI_OVER_30_Q24);
   localparam longint      DUTY_LIM    = 16384;
   localparam longint      DIFF_LIMIT  = (longint'(1) << 39) - 1;
   localparam longint      CURR_LIMIT  = (longint'(1) << 42) - 1;
   localparam longint      INT32_HI    = 2147483647;
   localparam longint      INT32_LO    = -INT32_HI - 1;
   localparam logic [sddc_pkg::CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [sddc_pkg::CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             csr_write_en;
   logic [sddc_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [sddc_pkg::CSR_DATA_W-1:0]  csr_wdata;

   sddc_req_if req_bus ();
   sddc_rsp_if rsp_bus ();

   skid_drive_dc_motor_torque_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_bus),
      .rsp_chan     (rsp_bus),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   longint                    volt_q8, kt_q16, gear_q8, cond_q16, tq_limit, dz_duty;
   longint                    duty_now [sddc_pkg::WHEEL_COUNT];
   sddc_pkg::rsp_payload_type duty_torque_q [$];
   int unsigned               send_idle_pct = 0;
   int unsigned               recv_stall_pct = 0;
   int                        rsp_hold_left = 0;
   int                        fault_count = 0;
   int                        quiet_cycles = 0;

   function automatic longint round_up_shift(longint x, int n);
      return (x + (longint'(1) << (n - 1))) >>> n;
   endfunction

   function automatic longint clip_sym(longint x, longint lim);
      if (x > lim) begin
         return lim;
      end else if (x < -lim) begin
         return -lim;
      end
      return x;
   endfunction

   function automatic longint drive_torque_model(longint speed, longint duty);
      longint mag, m, w, emf, drv, diff, cur, mt, wt;
      mag = (duty < 0) ? -duty : duty;
      if (speed == 0 && mag <= dz_duty) begin
         return 0;
      end
      m    = speed * gear_q8;
      w    = round_up_shift(m * PI_Q24, 24);
      emf  = round_up_shift(w * kt_q16, 16);
      drv  = round_up_shift(volt_q8 * duty, 6);
      diff = clip_sym(drv - emf, DIFF_LIMIT);
      cur  = clip_sym(round_up_shift(diff * cond_q16, 16), CURR_LIMIT);
      mt   = clip_sym(round_up_shift(cur * kt_q16, 16), tq_limit);
      wt   = round_up_shift(mt * gear_q8, 8);
      if (wt > INT32_HI) begin
         wt = INT32_HI;
      end
      if (wt < INT32_LO) begin
         wt = INT32_LO;
      end
      return wt;
   endfunction

   function automatic void motor_reset_state();
      volt_q8  = 3072;
      kt_q16   = 6554;
      gear_q8  = 12800;
      cond_q16 = 65536;
      tq_limit = 7714;
      dz_duty  = 0;
      for (int i = 0; i < sddc_pkg::WHEEL_COUNT; i++) begin
         duty_now[i] = 0;
      end
   endfunction

   function automatic sddc_pkg::rsp_payload_type motor_step(sddc_pkg::req_payload_type p);
      sddc_pkg::rsp_payload_type r;
      longint                    spd [sddc_pkg::WHEEL_COUNT];
      longint                    trq [sddc_pkg::WHEEL_COUNT];
      longint                    amt;
      r      = '0;
      amt    = longint'($signed(p.amount));
      spd[0] = longint'($signed(p.speed_front_left));
      spd[1] = longint'($signed(p.speed_front_right));
      spd[2] = longint'($signed(p.speed_rear_left));
      spd[3] = longint'($signed(p.speed_rear_right));
      for (int i = 0; i < sddc_pkg::WHEEL_COUNT; i++) begin
         trq[i] = 0;
      end
      case (sddc_pkg::action_type'(p.action))
         sddc_pkg::ACT_FORWARD: begin
            for (int i = 0; i < sddc_pkg::WHEEL_COUNT; i++) begin
               duty_now[i] = clip_sym(duty_now[i] + amt, DUTY_LIM);
            end
         end
         sddc_pkg::ACT_RIGHT: begin
            // right wheels turn the other way
            for (int i = 0; i < sddc_pkg::WHEEL_COUNT; i++) begin
               duty_now[i] = clip_sym(duty_now[i] + ((i % 2 == 1) ? -amt : amt), DUTY_LIM);
            end
         end
         sddc_pkg::ACT_SET: begin
            duty_now[0] = clip_sym(longint'($signed(p.duty_front_left)), DUTY_LIM);
            duty_now[1] = clip_sym(longint'($signed(p.duty_front_right)), DUTY_LIM);
            duty_now[2] = clip_sym(longint'($signed(p.duty_rear_left)), DUTY_LIM);
            duty_now[3] = clip_sym(longint'($signed(p.duty_rear_right)), DUTY_LIM);
         end
         default: begin
            r.torque_valid = 1'b1;
            for (int i = 0; i < sddc_pkg::WHEEL_COUNT; i++) begin
               trq[i] = drive_torque_model(spd[i], duty_now[i]);
            end
         end
      endcase
      r.torque_front_left    = 32'(trq[0]);
      r.torque_front_right   = 32'(trq[1]);
      r.torque_rear_left     = 32'(trq[2]);
      r.torque_rear_right    = 32'(trq[3]);
      r.now_duty_front_left  = 16'(duty_now[0]);
      r.now_duty_front_right = 16'(duty_now[1]);
      r.now_duty_rear_left   = 16'(duty_now[2]);
      r.now_duty_rear_right  = 16'(duty_now[3]);
      return r;
   endfunction

   function automatic string beat_text(sddc_pkg::rsp_payload_type r);
      return $sformatf("tv=%0b torque=%h/%h/%h/%h duty=%h/%h/%h/%h", r.torque_valid,
         r.torque_front_left, r.torque_front_right, r.torque_rear_left,
         r.torque_rear_right, r.now_duty_front_left, r.now_duty_front_right,
         r.now_duty_rear_left, r.now_duty_rear_right);
   endfunction

   function automatic logic [sddc_pkg::DUTY_W-1:0] pick_duty();
      if ($urandom_range(9) < 7) begin
         return 16'(int'($urandom_range(32768)) - 16384);
      end
      return 16'($urandom);
   endfunction

   function automatic logic [sddc_pkg::SPEED_W-1:0] pick_speed();
      case ($urandom_range(3))
         0: return '0;
         1: return 24'(int'($urandom_range(8191)) - 4096);
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic sddc_pkg::req_payload_type random_beat();
      sddc_pkg::req_payload_type p;
      int unsigned               pick;
      p.amount = $urandom_range(1) ? 16'($urandom) : 16'(int'($urandom_range(4095)) - 2048);
      p.duty_front_left   = pick_duty();
      p.duty_front_right  = pick_duty();
      p.duty_rear_left    = pick_duty();
      p.duty_rear_right   = pick_duty();
      p.speed_front_left  = pick_speed();
      p.speed_front_right = pick_speed();
      p.speed_rear_left   = pick_speed();
      p.speed_rear_right  = pick_speed();
      pick = $urandom_range(99);
      if (pick < 20) begin
         p.action = sddc_pkg::ACT_FORWARD;
      end else if (pick < 35) begin
         p.action = sddc_pkg::ACT_RIGHT;
      end else if (pick < 50) begin
         p.action = sddc_pkg::ACT_SET;
      end else begin
         p.action = sddc_pkg::ACT_TICK;
      end
      return p;
   endfunction

   task automatic send_item(input sddc_pkg::req_payload_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.payload <= p;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      duty_torque_q.push_back(motor_step(p));
   endtask

   task automatic send_move(input sddc_pkg::action_type a,
                            input logic [sddc_pkg::DUTY_W-1:0] amt);
      sddc_pkg::req_payload_type p;
      p        = random_beat();
      p.action = a;
      p.amount = amt;
      send_item(p);
   endtask

   task automatic send_set(input logic [sddc_pkg::DUTY_W-1:0] d0, d1, d2, d3);
      sddc_pkg::req_payload_type p;
      p                  = random_beat();
      p.action           = sddc_pkg::ACT_SET;
      p.duty_front_left  = d0;
      p.duty_front_right = d1;
      p.duty_rear_left   = d2;
      p.duty_rear_right  = d3;
      send_item(p);
   endtask

   task automatic send_tick(input logic [sddc_pkg::SPEED_W-1:0] s0, s1, s2, s3);
      sddc_pkg::req_payload_type p;
      p                   = random_beat();
      p.action            = sddc_pkg::ACT_TICK;
      p.speed_front_left  = s0;
      p.speed_front_right = s1;
      p.speed_rear_left   = s2;
      p.speed_rear_right  = s3;
      send_item(p);
   endtask

   task automatic wait_results_drained();
      req_bus.valid <= 1'b0;
      while (duty_torque_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [sddc_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [sddc_pkg::CSR_DATA_W-1:0] val);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      case (idx)
         sddc_pkg::CSR_SUPPLY_VOLTAGE:      volt_q8  = longint'(val[15:0]);
         sddc_pkg::CSR_TORQUE_GAIN:         kt_q16   = longint'(val[19:0]);
         sddc_pkg::CSR_GEAR_RATIO:          gear_q8  = longint'(val[15:0]);
         sddc_pkg::CSR_WINDING_CONDUCTANCE: cond_q16 = longint'(val[23:0]);
         sddc_pkg::CSR_TORQUE_LIMIT:        tq_limit = longint'(val[23:0]);
         sddc_pkg::CSR_DEAD_ZONE_DUTY:      dz_duty  = longint'(val[14:0]);
         default: ;
      endcase
   endtask

   task automatic load_config(input logic [sddc_pkg::CSR_DATA_W-1:0] v, kt, g, cond, lim, dz);
      wait_results_drained();
      write_csr(sddc_pkg::CSR_SUPPLY_VOLTAGE, v);
      write_csr(sddc_pkg::CSR_TORQUE_GAIN, kt);
      write_csr(sddc_pkg::CSR_GEAR_RATIO, g);
      write_csr(sddc_pkg::CSR_WINDING_CONDUCTANCE, cond);
      write_csr(sddc_pkg::CSR_TORQUE_LIMIT, lim);
      write_csr(sddc_pkg::CSR_DEAD_ZONE_DUTY, dz);
   endtask

   task automatic load_realistic_config();
      load_config(24'($urandom_range(12288, 1024)), 24'($urandom_range(20000, 500)),
                  24'($urandom_range(25600, 256)), 24'($urandom_range(655360, 6554)),
                  24'($urandom_range(200000, 1000)), 24'($urandom_range(2000)));
   endtask

   task automatic test_duty_moves();
      send_tick(24'h000000, 24'h000000, 24'h000000, 24'h000000);
      send_move(sddc_pkg::ACT_FORWARD, 16'h7FFF);
      send_tick(24'h000000, 24'h000000, 24'h000000, 24'h000000);
      send_move(sddc_pkg::ACT_FORWARD, 16'h8000);
      send_move(sddc_pkg::ACT_FORWARD, 16'h8000);
      send_move(sddc_pkg::ACT_RIGHT, 16'h7FFF);
      send_tick(24'h7FFFFF, 24'h800000, 24'h000001, 24'hFFFFFF);
      send_move(sddc_pkg::ACT_RIGHT, 16'h8000);
      send_move(sddc_pkg::ACT_FORWARD, 16'h0000);
      send_set(16'h7FFF, 16'h8000, 16'h4000, 16'hC000);
      send_set(16'h4001, 16'hBFFF, 16'h0000, 16'h0001);
      send_tick(24'h000000, 24'h000000, 24'h000000, 24'h000000);
      send_tick(24'h000100, 24'hFFFF00, 24'h012345, 24'hFEDCBA);
   endtask

   task automatic test_dead_zone();
      wait_results_drained();
      // unmapped indexes must leave every register alone
      write_csr(CSR_SPARE_LO, 24'($urandom));
      write_csr(CSR_SPARE_HI, 24'($urandom));
      write_csr(sddc_pkg::CSR_DEAD_ZONE_DUTY, 24'd100);
      send_set(16'd100, 16'hFF9C, 16'd101, 16'hFF9B);
      send_tick(24'h000000, 24'h000000, 24'h000000, 24'h000000);
      send_tick(24'h000001, 24'h000000, 24'h000000, 24'hFFFFFF);
      wait_results_drained();
      write_csr(sddc_pkg::CSR_DEAD_ZONE_DUTY, 24'd16384);
      send_set(16'h4000, 16'hC000, 16'h0000, 16'h3FFF);
      send_tick(24'h000000, 24'h000000, 24'h000000, 24'h000000);
   endtask

   task automatic test_saturation();
      load_config(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      send_set(16'h4000, 16'hC000, 16'h4000, 16'hC000);
      send_tick(24'h7FFFFF, 24'h800000, 24'h000001, 24'hFFFFFF);
      send_tick(24'h800000, 24'h7FFFFF, 24'hFFFFFF, 24'h000001);
      wait_results_drained();
      write_csr(sddc_pkg::CSR_DEAD_ZONE_DUTY, 24'd0);
      send_tick(24'h000000, 24'h000000, 24'h000000, 24'h000000);
      load_config(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
      send_tick(24'h000000, 24'h123456, 24'h7FFFFF, 24'h800000);
   endtask

   task automatic test_random_traffic(input int n, input int unsigned s_pct, r_pct);
      send_idle_pct  = s_pct;
      recv_stall_pct = r_pct;
      repeat (n) send_item(random_beat());
   endtask

   task automatic test_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      rsp_hold_left  = 300;
      repeat (12) send_item(random_beat());
      wait_results_drained();
      repeat (6) send_item(random_beat());
   endtask

   task automatic check_beat(input sddc_pkg::rsp_payload_type got);
      sddc_pkg::rsp_payload_type want;
      if (duty_torque_q.size() == 0) begin
         fault_count++;
         if (fault_count <= 10) begin
            $display("unexpected result beat: %s", beat_text(got));
         end
      end else begin
         want = duty_torque_q.pop_front();
         if (got.torque_valid !== want.torque_valid ||
             got.torque_front_left !== want.torque_front_left ||
             got.torque_front_right !== want.torque_front_right ||
             got.torque_rear_left !== want.torque_rear_left ||
             got.torque_rear_right !== want.torque_rear_right ||
             got.now_duty_front_left !== want.now_duty_front_left ||
             got.now_duty_front_right !== want.now_duty_front_right ||
             got.now_duty_rear_left !== want.now_duty_rear_left ||
             got.now_duty_rear_right !== want.now_duty_rear_right) begin
            fault_count++;
            if (fault_count <= 10) begin
               $display("mismatch want %s", beat_text(want));
               $display("         got  %s", beat_text(got));
            end
         end
      end
   endtask

   task automatic finish_run();
      wait_results_drained();
      repeat (100) @(posedge clock);
      if (duty_torque_q.size() != 0) begin
         fault_count++;
      end
      if (fault_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   endtask

   // result side: check each beat, then drive ready
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            check_beat(rsp_bus.payload);
         end
         if (rsp_hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_hold_left--;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.payload <= '0;
      csr_write_en    <= 1'b0;
      csr_index       <= '0;
      csr_wdata       <= '0;
      motor_reset_state();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_duty_moves();
      test_dead_zone();
      test_saturation();
      load_config(24'd3072, 24'd6554, 24'd12800, 24'd65536, 24'd7714, 24'd0);
      test_random_traffic(150, 0, 0);
      load_realistic_config();
      test_random_traffic(200, 78, 0);
      load_config(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'd0);
      test_random_traffic(120, 0, 78);
      load_realistic_config();
      test_backpressure();
      load_config(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                  24'($urandom), 24'($urandom));
      test_random_traffic(180, 15, 15);
      load_config(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
      test_random_traffic(60, 15, 15);
      load_realistic_config();
      test_random_traffic(220, 0, 0);
      finish_run();
   end

endmodule
